>>> src/assert_macros.svh
// Assertion macros for the port-level checker of the UTF-16 decoder.
// Depends on nothing; ASSERT_CLK expects clk and rst_n in scope, ASSERT_CLK_RST only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/u16d_pkg.sv
// Package for the UTF-16 byte stream decoder: widths, register indexes,
// reset values, unit ranges and the control struct of the unit decoder.
package u16d_pkg;

  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int CP_W    = 31;
  localparam int SUR_W   = 10;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_START_LE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUP_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUP_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FLAG  = 3'd4;

  localparam logic [CP_W-1:0] SUP_MIN_RST  = 31'h0001_0000;
  localparam logic [CP_W-1:0] SUP_MAX_RST  = 31'h0020_0000;
  localparam logic [CP_W-1:0] INV_MASK_RST = 31'h00FF_FFFF;
  localparam logic [CP_W-1:0] INV_FLAG_RST = 31'h7800_0000;

  localparam logic [UNIT_W-1:0] HIGH_SUR_LO = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_SUR_HI = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_SUR_LO  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_SUR_HI  = 16'hDFFF;
  localparam logic [UNIT_W-1:0] BOM_SWAPPED = 16'hFFFE;
  localparam logic [UNIT_W-1:0] BOM_NATIVE  = 16'hFEFF;
  localparam logic [CP_W-1:0]   SUP_OFFSET  = 31'h0001_0000;

  // What the unit decoder asks of the state registers
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] value;
    logic            hold_high;   // load pending bits, set pending
    logic            clear_high;
    logic            flip_order;
    logic            mark_first;
  } u16d_ctl_t;

endpackage

>>> src/u16d_unit_decode.sv
// Decodes one assembled 16-bit unit against the surrogate and BOM state.
// Purely combinational; depends on u16d_pkg.
module u16d_unit_decode
  import u16d_pkg::*;
(
  input  logic [UNIT_W-1:0] unit,
  input  logic              high_pending,
  input  logic [SUR_W-1:0]  pending_bits,
  input  logic              first_seen,
  input  logic [CP_W-1:0]   sup_min,
  input  logic [CP_W-1:0]   sup_max,
  input  logic [CP_W-1:0]   inv_mask,
  input  logic [CP_W-1:0]   inv_flag,
  output u16d_ctl_t         ctl
);

  logic            is_high;
  logic            is_low;
  logic [CP_W-1:0] pair_val;
  logic            in_range;

  always_comb begin
    is_high = unit inside {[HIGH_SUR_LO:HIGH_SUR_HI]};
    is_low  = unit inside {[LOW_SUR_LO:LOW_SUR_HI]};

    // A lone low surrogate carries only its own ten bits
    if (high_pending) begin
      pair_val = {11'd0, pending_bits, unit[SUR_W-1:0]} + SUP_OFFSET;
    end else begin
      pair_val = {21'd0, unit[SUR_W-1:0]};
    end
    in_range = (pair_val >= sup_min) && (pair_val < sup_max);

    ctl = '0;
    if (is_high) begin
      ctl.hold_high = 1'b1;
    end else if (is_low) begin
      ctl.clear_high = 1'b1;
      ctl.emit       = 1'b1;
      ctl.value      = in_range ? pair_val : ((pair_val & inv_mask) | inv_flag);
    end else begin
      ctl.clear_high = 1'b1;
      ctl.value      = {15'd0, unit};
      ctl.emit       = 1'b1;
      if (!first_seen) begin
        ctl.mark_first = 1'b1;
        // Byte order mark on the first plain unit: swallow it
        if (unit == BOM_SWAPPED) begin
          ctl.flip_order = 1'b1;
          ctl.emit       = 1'b0;
        end else if (unit == BOM_NATIVE) begin
          ctl.emit       = 1'b0;
        end
      end
    end
  end

endmodule

>>> src/utf16_byte_stream_decoder_top.sv
// UTF-16 byte stream decoder, top level: byte pairing, state and result register.
// Depends on u16d_pkg and u16d_unit_decode.
//
// Usage:
//   Input channel in_valid/in_stall/in_byte carries one raw byte per request.
//   Two bytes form a unit, big- or little-endian as the current byte order says.
//   Output channel out_valid/out_stall/out_code_point carries decoded code points.
//   A byte is taken in every cycle in which the result register is empty or is
//   being emptied; in_stall follows out_stall only while a result is waiting.
//   A result appears in the cycle after the second byte of its unit is taken.
//   Throughput: one byte per cycle while no waiting result is stalled; the limit is the single result register.
//   High surrogates and a byte order mark as the first plain unit produce no result.
//   While out_stall is high the held result and its valid do not change.
//   Reset (synchronous, rst_n low) empties the result register, restores the
//   register defaults and big-endian order. A write of start_little_endian
//   clears the decode state and loads the byte order; other writes keep it.
//   Write configuration only while no request is in flight.
module utf16_byte_stream_decoder_top
  import u16d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CP_W-1:0]      out_code_point,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CP_W-1:0]      cfg_wdata
);

  logic [CP_W-1:0]   sup_min_r;
  logic [CP_W-1:0]   sup_max_r;
  logic [CP_W-1:0]   inv_mask_r;
  logic [CP_W-1:0]   inv_flag_r;

  logic              phase_r;
  logic [BYTE_W-1:0] held_byte_r;
  logic [SUR_W-1:0]  pend_bits_r;
  logic              high_pend_r;
  logic              little_r;
  logic              first_seen_r;

  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;

  logic              in_acc;
  logic              unit_done;
  logic [UNIT_W-1:0] unit;
  u16d_ctl_t         ctl;

  assign in_stall       = out_valid_r && out_stall;
  assign in_acc         = in_valid && !in_stall;
  assign unit_done      = in_acc && phase_r;
  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;

  assign unit = little_r ? {in_byte, held_byte_r} : {held_byte_r, in_byte};

  u16d_unit_decode u_dec (
    .unit         (unit),
    .high_pending (high_pend_r),
    .pending_bits (pend_bits_r),
    .first_seen   (first_seen_r),
    .sup_min      (sup_min_r),
    .sup_max      (sup_max_r),
    .inv_mask     (inv_mask_r),
    .inv_flag     (inv_flag_r),
    .ctl          (ctl)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_min_r  <= SUP_MIN_RST;
      sup_max_r  <= SUP_MAX_RST;
      inv_mask_r <= INV_MASK_RST;
      inv_flag_r <= INV_FLAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        // byte order goes straight into the decode state
        CFG_START_LE: ;
        CFG_SUP_MIN:  sup_min_r  <= cfg_wdata;
        CFG_SUP_MAX:  sup_max_r  <= cfg_wdata;
        CFG_INV_MASK: inv_mask_r <= cfg_wdata;
        CFG_INV_FLAG: inv_flag_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 1'b0;
      held_byte_r  <= '0;
      pend_bits_r  <= '0;
      high_pend_r  <= 1'b0;
      little_r     <= 1'b0;
      first_seen_r <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_START_LE)) begin
      phase_r      <= 1'b0;
      held_byte_r  <= '0;
      pend_bits_r  <= '0;
      high_pend_r  <= 1'b0;
      little_r     <= cfg_wdata[0];
      first_seen_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= !phase_r;
      if (!phase_r) begin
        held_byte_r <= in_byte;
      end else begin
        if (ctl.hold_high) begin
          pend_bits_r <= unit[SUR_W-1:0];
          high_pend_r <= 1'b1;
        end else if (ctl.clear_high) begin
          pend_bits_r <= '0;
          high_pend_r <= 1'b0;
        end
        if (ctl.flip_order) begin
          little_r <= !little_r;
        end
        if (ctl.mark_first) begin
          first_seen_r <= 1'b1;
        end
      end
    end
  end

  // Result register: drain on take, load on a new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (unit_done && ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_done && ctl.emit) begin
      out_cp_r <= ctl.value;
    end
  end

endmodule

>>> src/u16d_checker.sv
// Port-level checker for the UTF-16 decoder top level, attached by bind.
// Depends on assert_macros.svh and u16d_pkg.
`include "assert_macros.svh"

module u16d_checker
  import u16d_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [BYTE_W-1:0]    in_byte,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [CP_W-1:0]      out_code_point
);

  `ASSERT_CLK(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_code_point),
    "result changed while stalled")
  `ASSERT_CLK(a_in_hold,
    in_valid && in_stall |=> in_valid && $stable(in_byte),
    "request changed while stalled")
  `ASSERT_CLK(a_rose_from_req,
    $rose(out_valid) |-> $past(in_valid && !in_stall),
    "result appeared without an accepted request")
  `ASSERT_CLK(a_stall_only_full,
    in_stall |-> out_valid && out_stall,
    "input stalled with result register free")
  `ASSERT_CLK_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid straight after reset")

endmodule

bind utf16_byte_stream_decoder_top u16d_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_byte        (in_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_code_point (out_code_point)
);

>>> verif/u16d_stream_checker.sv
`timescale 1ns / 1ps
// Checker for the UTF-16 byte stream decoder: watches the byte, result and
// register ports, predicts the decoded code points and compares them in order.
// Depends on u16d_pkg.
module u16d_stream_checker
  import u16d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CP_W-1:0]      out_code_point,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CP_W-1:0]      cfg_wdata,
  output int unsigned          cps_outstanding,
  output int unsigned          mismatch_count
);

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] cp;
  } decoded_t;

  // Register copies
  logic            le_start;
  logic [CP_W-1:0] cp_lo;
  logic [CP_W-1:0] cp_hi;
  logic [CP_W-1:0] bad_mask;
  logic [CP_W-1:0] bad_flag;

  // Decode state
  logic              unit_half_held;
  logic [BYTE_W-1:0] unit_first_byte;
  logic [SUR_W-1:0]  high_bits;
  logic              high_held;
  logic              order_le;
  logic              first_unit_done;

  logic [CP_W-1:0] expected_cps[$];
  int unsigned     errors = 0;

  function automatic void clear_decode();
    unit_half_held  = 1'b0;
    unit_first_byte = '0;
    high_bits       = '0;
    high_held       = 1'b0;
    order_le        = le_start;
    first_unit_done = 1'b0;
  endfunction

  function automatic decoded_t decode_byte(input logic [BYTE_W-1:0] b);
    decoded_t        res;
    logic [UNIT_W-1:0] unit;
    logic [CP_W-1:0] v;
    res = '0;
    if (!unit_half_held) begin
      unit_first_byte = b;
      unit_half_held  = 1'b1;
      return res;
    end
    unit_half_held = 1'b0;
    unit = order_le ? {b, unit_first_byte} : {unit_first_byte, b};

    if (unit >= HIGH_SUR_LO && unit <= HIGH_SUR_HI) begin
      // hold the high half, a later one replaces it
      high_bits = unit[SUR_W-1:0];
      high_held = 1'b1;
      return res;
    end
    if (unit >= LOW_SUR_LO && unit <= LOW_SUR_HI) begin
      v = {{(CP_W-SUR_W){1'b0}}, unit[SUR_W-1:0]};
      if (high_held)
        v = v + ({{(CP_W-SUR_W){1'b0}}, high_bits} << SUR_W) + SUP_OFFSET;
      high_bits = '0;
      high_held = 1'b0;
      if (!(v >= cp_lo && v < cp_hi))
        v = (v & bad_mask) | bad_flag;
      res.emit = 1'b1;
      res.cp   = v;
      return res;
    end

    // plain unit: drop any orphan high half
    high_bits = '0;
    high_held = 1'b0;
    if (!first_unit_done) begin
      first_unit_done = 1'b1;
      if (unit == BOM_SWAPPED) begin
        order_le = !order_le;
        return res;
      end
      if (unit == BOM_NATIVE)
        return res;
    end
    res.emit = 1'b1;
    res.cp   = {{(CP_W-UNIT_W){1'b0}}, unit};
    return res;
  endfunction

  always @(posedge clk) begin : watch
    decoded_t        d;
    logic [CP_W-1:0] want;
    if (!rst_n) begin
      le_start = 1'b0;
      cp_lo    = SUP_MIN_RST;
      cp_hi    = SUP_MAX_RST;
      bad_mask = INV_MASK_RST;
      bad_flag = INV_FLAG_RST;
      clear_decode();
      expected_cps.delete();
    end else begin
      // a result always trails its byte, so check before predicting
      if (out_valid && !out_stall) begin
        if (expected_cps.size() == 0) begin
          $error("code_point: no result expected, got %0h", out_code_point);
          errors++;
        end else begin
          want = expected_cps.pop_front();
          if (out_code_point !== want) begin
            $error("code_point: expected %0h, got %0h", want, out_code_point);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_LE: begin
            le_start = cfg_wdata[0];
            clear_decode();
          end
          CFG_SUP_MIN:  cp_lo    = cfg_wdata;
          CFG_SUP_MAX:  cp_hi    = cfg_wdata;
          CFG_INV_MASK: bad_mask = cfg_wdata;
          CFG_INV_FLAG: bad_flag = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        d = decode_byte(in_byte);
        if (d.emit)
          expected_cps.push_back(d.cp);
      end
    end
    cps_outstanding <= expected_cps.size();
    mismatch_count  <= errors;
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the UTF-16 byte stream decoder: clock, reset, byte and
// register stimulus, random stalls and the verdict. Depends on u16d_pkg,
// utf16_byte_stream_decoder_top and u16d_stream_checker.
module tb_top;
  import u16d_pkg::*;

  localparam int unsigned HANG_LIMIT  = 2000;
  localparam int unsigned PHASE_BYTES = 500;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CP_W-1:0]      cfg_wdata = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [CP_W-1:0]      out_code_point;

  int unsigned cps_outstanding;
  int unsigned mismatch_count;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned idle_cycles    = 0;
  logic        stream_le      = 1'b0;

  utf16_byte_stream_decoder_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  u16d_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cps_outstanding (cps_outstanding),
    .mismatch_count  (mismatch_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // End the run if nothing moves on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == HANG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_unit(input logic [UNIT_W-1:0] u);
    if (stream_le) begin
      push_byte(u[7:0]);
      push_byte(u[15:8]);
    end else begin
      push_byte(u[15:8]);
      push_byte(u[7:0]);
    end
  endtask

  // Hold off the sender until every predicted code point has come out
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cps_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic le, input logic [CP_W-1:0] lo,
                               input logic [CP_W-1:0] hi, input logic [CP_W-1:0] mask,
                               input logic [CP_W-1:0] flag);
    logic [CP_W-1:0] word;
    word    = CP_W'($urandom);
    word[0] = le;
    write_reg(CFG_START_LE, word);
    write_reg(CFG_SUP_MIN, lo);
    write_reg(CFG_SUP_MAX, hi);
    write_reg(CFG_INV_MASK, mask);
    write_reg(CFG_INV_FLAG, flag);
    cfg_we    <= 1'b0;
    stream_le = le;
  endtask

  // Mostly well-formed units and pairs, some broken ones and stray bytes
  task automatic push_random_run();
    int unsigned       pick;
    logic [UNIT_W-1:0] u;
    logic [SUR_W-1:0]  r10;
    pick = $urandom_range(99);
    u    = UNIT_W'($urandom);
    r10  = SUR_W'($urandom);
    if (pick < 35) begin
      if (u >= HIGH_SUR_LO && u <= LOW_SUR_HI)
        u = u ^ 16'h4000;
      push_unit(u);
    end else if (pick < 70) begin
      push_unit(HIGH_SUR_LO | {6'd0, r10});
      r10 = SUR_W'($urandom);
      push_unit(LOW_SUR_LO | {6'd0, r10});
    end else if (pick < 78) begin
      push_unit(LOW_SUR_LO | {6'd0, r10});
    end else if (pick < 86) begin
      push_unit(HIGH_SUR_LO | {6'd0, r10});
    end else if (pick < 90) begin
      push_unit($urandom_range(1) ? BOM_NATIVE : BOM_SWAPPED);
    end else if (pick < 98) begin
      push_unit(u);
    end else begin
      // stray byte shifts the pairing
      push_byte(u[7:0]);
    end
  endtask

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, big-endian
    push_unit(BOM_NATIVE);
    push_unit(16'h0041);
    push_unit(BOM_NATIVE);
    push_unit(HIGH_SUR_HI);
    push_unit(LOW_SUR_HI);
    push_unit(LOW_SUR_LO | 16'h0005);
    push_unit(HIGH_SUR_LO | 16'h0001);
    push_unit(16'h0042);
    push_unit(HIGH_SUR_LO | 16'h0001);
    push_unit(HIGH_SUR_LO | 16'h0302);
    push_unit(LOW_SUR_LO | 16'h0003);
    push_unit(16'hFFFF);
    push_unit(HIGH_SUR_LO | 16'h01AB);
    wait_until_drained();

    // A held high half survives a write to anything but the byte order
    write_reg(CFG_SUP_MIN, '0);
    cfg_we <= 1'b0;
    push_unit(LOW_SUR_LO | 16'h0011);
    push_byte(8'hAA);
    wait_until_drained();

    for (int i = CFG_INV_FLAG + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CP_W'($urandom));
    load_settings(1'b1, '1, '0, '0, '1);
    push_unit(BOM_SWAPPED);
    stream_le = !stream_le;
    push_unit(LOW_SUR_LO | 16'h02A5);
    push_unit(16'h1234);
    push_unit(HIGH_SUR_LO | 16'h0155);
    push_unit(LOW_SUR_LO | 16'h02AA);
    wait_until_drained();

    for (int p = 0; p < 4; p++) begin
      if (p == 0)
        load_settings(1'($urandom_range(1)), '0, '1, CP_W'($urandom), CP_W'($urandom));
      else
        load_settings(1'($urandom_range(1)), CP_W'($urandom_range(32'h0011_0000)),
                      CP_W'($urandom_range(32'h0011_0000)), CP_W'($urandom),
                      CP_W'($urandom));
      send_idle_pct  = (p == 1) ? 61 : (p == 3) ? 33 : 0;
      recv_stall_pct = (p == 2) ? 61 : (p == 3) ? 33 : 0;
      case ($urandom_range(2))
        0: push_unit(BOM_NATIVE);
        1: begin
          push_unit(BOM_SWAPPED);
          stream_le = !stream_le;
        end
        default: ;
      endcase
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal)
        push_random_run();
      send_idle_pct = 0;
      wait_until_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
